@@ sv/sfr_pkg.sv @@
`default_nettype none
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 4;
  localparam int WORD_W = 64;
  localparam int IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_PATTERN_LEN  = 2'd0,
    REG_PATTERN_WORD = 2'd1,
    REG_REPL_LEN     = 2'd2,
    REG_REPL_WORD    = 2'd3
  } sfr_reg_t;

  // Per-cycle control shared by every window cell
  typedef struct packed {
    logic en;
    logic shift;
  } sfr_cell_ctl_t;

  // Load request into the output queue
  typedef struct packed {
    logic load;
    logic has;
    logic last;
  } sfr_load_t;

endpackage
`default_nettype wire

@@ sv/sfr_if.sv @@
`default_nettype none
interface sfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::BYTE_W-1:0]   in_byte;
  logic                         in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::BYTE_W-1:0]   out_byte;
  logic                         has_byte;
  logic                         out_last;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::IDX_W-1:0]    index;
  logic [sfr_pkg::WORD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/stream_find_replace.sv @@
`default_nettype none
// Channel | Dir | Payload                        | Transfer
// src     | in  | in_byte[7:0], in_last          | valid & ready
// dst     | out | out_byte[7:0], has_byte, last  | valid & ready
// cfg     | in  | index[1:0], data[63:0]         | valid & ready (ready always high)
//
// An input byte is taken in the cycle after the previous one when that byte
// gave no result, or one that dst takes; an item that gives k results holds
// src.ready low while the queue drains one result per cycle with dst.ready high.
// rst is synchronous and clears the registers, the window fill and the queue.
// src.ready follows dst.ready combinationally when one result is pending.
module stream_find_replace #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPL    = 8
) (
  input  wire         clk,
  input  wire         rst,
  sfr_in_if.sink      src,
  sfr_out_if.source   dst,
  sfr_cfg_if.sink     cfg
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int Q  = (MAX_PATTERN > MAX_REPL) ? MAX_PATTERN : MAX_REPL;
  localparam int QW = $clog2(Q + 1);

  logic [sfr_pkg::LEN_W-1:0]  pattern_len;
  logic [sfr_pkg::WORD_W-1:0] pattern_word;
  logic [sfr_pkg::LEN_W-1:0]  repl_len;
  logic [sfr_pkg::WORD_W-1:0] repl_word;

  logic [CW-1:0] win_cnt;
  logic [CW-1:0] win_cnt_next;
  logic [CW-1:0] p_eff;
  logic [CW-1:0] cnt_eff;
  logic [QW-1:0] r_eff;
  logic          accept;
  logic          full;
  logic          match;
  logic          plen_wr;

  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] cand;
  logic [MAX_PATTERN-1:0]                      eq;
  logic [MAX_PATTERN-1:0]                      sel;
  logic [MAX_PATTERN-1:0]                      in_use;
  logic [Q-1:0][sfr_pkg::BYTE_W-1:0]           cand_q;
  logic [Q-1:0][sfr_pkg::BYTE_W-1:0]           repl_q;
  logic [Q-1:0][sfr_pkg::BYTE_W-1:0]           ld_bytes;
  logic [QW-1:0]                               ld_cnt;
  logic [QW-1:0]                               q_fill;
  logic                                        can_load;
  sfr_pkg::sfr_load_t                          ld;
  sfr_pkg::sfr_cell_ctl_t                      cell_ctl;

  // Configuration registers
  assign cfg.ready = 1'b1;
  assign plen_wr   = cfg.valid && (cfg.index == sfr_pkg::REG_PATTERN_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      pattern_word <= '0;
      repl_len     <= '0;
      repl_word    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sfr_pkg::REG_PATTERN_LEN:  pattern_len  <= cfg.data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_PATTERN_WORD: pattern_word <= cfg.data;
        sfr_pkg::REG_REPL_LEN:     repl_len     <= cfg.data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPL_WORD:    repl_word    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Lengths above the built size saturate
  assign p_eff = (pattern_len > sfr_pkg::LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                              : CW'(pattern_len);
  assign r_eff = (repl_len > sfr_pkg::LEN_W'(MAX_REPL)) ? QW'(MAX_REPL)
                                                        : QW'(repl_len);

  assign accept  = src.valid && src.ready;
  assign src.ready = can_load;

  assign cnt_eff = (win_cnt >= p_eff) ? '0 : win_cnt;
  assign full    = (CW'(cnt_eff + CW'(1)) == p_eff);
  assign match   = &(eq | ~in_use);

  assign cell_ctl.en    = accept && (p_eff != '0);
  assign cell_ctl.shift = full && !match;

  // Window: one cell per pattern byte, each compares its own byte
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [sfr_pkg::BYTE_W-1:0] nbr;
    if (i == MAX_PATTERN - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cand[i+1];
    end
    assign sel[i]    = (cnt_eff == CW'(i));
    assign in_use[i] = (CW'(i) < p_eff);

    sfr_win_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .sel      (sel[i]),
      .new_byte (src.in_byte),
      .nbr_cand (nbr),
      .pat_byte (pattern_word[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]),
      .cand     (cand[i]),
      .eq       (eq[i])
    );
  end

  always_comb begin
    win_cnt_next = win_cnt;
    if (plen_wr) begin
      win_cnt_next = '0;
    end else if (accept && (p_eff != '0)) begin
      priority if (src.in_last) begin
        win_cnt_next = '0;
      end else if (full && match) begin
        win_cnt_next = '0;
      end else if (full) begin
        win_cnt_next = p_eff - CW'(1);
      end else begin
        win_cnt_next = cnt_eff + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cnt <= '0;
    end else begin
      win_cnt <= win_cnt_next;
    end
  end

  always_comb begin
    cand_q = '0;
    repl_q = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cand_q[i] = cand[i];
    end
    for (int i = 0; i < MAX_REPL; i++) begin
      repl_q[i] = repl_word[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
    end
  end

  // Results of the accepted byte, loaded as one batch into the queue
  always_comb begin
    ld.load  = accept;
    ld.last  = src.in_last;
    ld.has   = 1'b1;
    ld_bytes = cand_q;
    ld_cnt   = '0;
    priority if (p_eff == '0) begin
      ld_bytes    = '0;
      ld_bytes[0] = src.in_byte;
      ld_cnt      = QW'(1);
    end else if (full && match) begin
      ld_bytes = repl_q;
      ld_cnt   = r_eff;
      if (src.in_last && (r_eff == '0)) begin
        // empty output string: bare end marker
        ld_bytes = '0;
        ld_cnt   = QW'(1);
        ld.has   = 1'b0;
      end
    end else if (full) begin
      ld_cnt = src.in_last ? QW'(p_eff) : QW'(1);
    end else begin
      ld_cnt = src.in_last ? (QW'(cnt_eff) + QW'(1)) : '0;
    end
  end

  sfr_out_queue #(
    .DEPTH (Q),
    .CW    (QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .ld_cnt   (ld_cnt),
    .ld_bytes (ld_bytes),
    .can_load (can_load),
    .fill     (q_fill),
    .dst      (dst)
  );

  a_load_when_draining: assert property (@(posedge clk) disable iff (rst)
    accept |-> (q_fill == '0) || ((q_fill == QW'(1)) && dst.ready))
    else $error("queue loaded while results still pending");

  a_window_below_pattern: assert property (@(posedge clk) disable iff (rst)
    (win_cnt < p_eff) || (win_cnt == '0))
    else $error("window fill reached pattern length");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && !dst.has_byte) |-> (dst.out_last && (dst.out_byte == '0)))
    else $error("bare marker not at end of string");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && src.in_last) |=> (win_cnt == '0))
    else $error("window not flushed after last byte");

endmodule
`default_nettype wire

@@ sv/sfr_win_cell.sv @@
`default_nettype none
module sfr_win_cell (
  input  wire                           clk,
  input  sfr_pkg::sfr_cell_ctl_t        ctl,
  input  wire                           sel,
  input  wire [sfr_pkg::BYTE_W-1:0]     new_byte,
  input  wire [sfr_pkg::BYTE_W-1:0]     nbr_cand,
  input  wire [sfr_pkg::BYTE_W-1:0]     pat_byte,
  output logic [sfr_pkg::BYTE_W-1:0]    cand,
  output logic                          eq
);

  logic [sfr_pkg::BYTE_W-1:0] stored;

  // The arriving byte lands in the cell that sits at the current fill point
  assign cand = sel ? new_byte : stored;
  assign eq   = (cand == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      stored <= ctl.shift ? nbr_cand : cand;
    end
  end

endmodule
`default_nettype wire

@@ sv/sfr_out_queue.sv @@
`default_nettype none
module sfr_out_queue #(
  parameter int DEPTH = 8,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  sfr_pkg::sfr_load_t                    ld,
  input  wire [CW-1:0]                          ld_cnt,
  input  wire [DEPTH-1:0][sfr_pkg::BYTE_W-1:0]  ld_bytes,
  output logic                                  can_load,
  output logic [CW-1:0]                         fill,
  sfr_out_if.source                             dst
);

  logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] bytes;
  logic [CW-1:0]                         cnt;
  logic                                  has;
  logic                                  last;
  logic                                  pop;

  assign pop      = dst.valid && dst.ready;
  assign can_load = (cnt == '0) || ((cnt == CW'(1)) && dst.ready);
  assign fill     = cnt;

  assign dst.valid    = (cnt != '0);
  assign dst.out_byte = bytes[0];
  assign dst.has_byte = has;
  assign dst.out_last = last && (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      has  <= 1'b0;
      last <= 1'b0;
    end else if (ld.load) begin
      cnt  <= ld_cnt;
      has  <= ld.has;
      last <= ld.last;
    end else if (pop) begin
      cnt  <= cnt - CW'(1);
    end
  end

  // Byte chain: each slot hands its byte toward the head on every transfer that is not also a load
  always_ff @(posedge clk) begin
    if (ld.load) begin
      bytes <= ld_bytes;
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
    end
  end

endmodule
`default_nettype wire
